>>> rtl/assert_macros.svh
// Assertion macros used by the scheduler top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define PPS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication outside reset.
`define PPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

>>> rtl/pps_pkg.sv
// Package with types and constants of the priority scheduler.
`default_nettype none
package pps_pkg;
	localparam int MaxProcs = 16;
	localparam int IdxW = $clog2(MaxProcs);
	localparam int CntW = $clog2(MaxProcs + 1);
	localparam int MaxReport = 16;
	localparam logic [20:0] Max21 = 21'h1FFFFF;
	localparam int QDepth = 2;

	typedef enum logic [1:0] {
		MODE_LOAD = 2'd0,
		MODE_TICK = 2'd1,
		MODE_REPORT = 2'd2,
		MODE_CLEAR = 2'd3
	} mode_t;

	typedef struct packed {
		mode_t mode;
		logic [15:0] arrival;
		logic [15:0] burst;
		logic [7:0] prio;
	} req_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_UPD,
		ST_TOUT,
		ST_REP
	} state_t;
endpackage
`default_nettype wire

>>> rtl/preemptive_priority_scheduler_unit.sv
// Top level of the preemptive priority scheduler.
// A request waits in the front-end queue registers; load and clear are done in the idle state.
// A tick scans the loaded processes in turn (at least one), then updates and outputs a result.
// A report gives one entry per cycle while the output is taken.
// The back end serves one request at a time; a two-entry queue decouples the input.
// Asynchronous reset clears time, table count and the previous runner; table contents are kept.
`default_nettype none
`include "assert_macros.svh"
module preemptive_priority_scheduler_unit (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [1:0] mode,
	input wire logic [15:0] arrival,
	input wire logic [15:0] burst,
	input wire logic [7:0] prio,
	output logic out_valid,
	input wire logic out_ready,
	output logic result_kind,
	output logic [3:0] proc_id,
	output logic idle,
	output logic switched,
	output logic finished,
	output logic [20:0] wait_time,
	output logic [20:0] turnaround,
	output logic last
);
	pps_pkg::req_t in_req, q_req;
	logic q_valid, q_ready;

	assign in_req.mode = pps_pkg::mode_t'(mode);
	assign in_req.arrival = arrival;
	assign in_req.burst = burst;
	assign in_req.prio = prio;

	pps_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.in_req(in_req), .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req)
	);

	pps_back u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req),
		.out_valid(out_valid), .out_ready(out_ready), .result_kind(result_kind),
		.proc_id(proc_id), .idle(idle), .switched(switched), .finished(finished),
		.wait_time(wait_time), .turnaround(turnaround), .last(last)
	);

	`PPS_ASSERT_IMP(a_idle_id, clk, arst_n, out_valid && !result_kind && idle, proc_id == 4'd0)
	`PPS_ASSERT_IMP(a_tick_last, clk, arst_n, out_valid && !result_kind, last && wait_time == 21'd0)
	`PPS_ASSERT_IMP(a_idle_nofin, clk, arst_n, out_valid && idle, !finished)
endmodule
`default_nettype wire

>>> rtl/pps_front.sv
// Front end: takes requests and queues them.
`default_nettype none
module pps_front (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire pps_pkg::req_t in_req,
	output logic q_valid,
	input wire logic q_ready,
	output pps_pkg::req_t q_req
);
	pps_pkg::req_t mem_q [pps_pkg::QDepth];
	logic rd_q, wr_q;
	logic [1:0] cnt_q;
	logic push, pop;

	assign in_ready = (cnt_q != 2'(pps_pkg::QDepth));
	assign push = in_valid && in_ready;
	assign pop = q_valid && q_ready;
	assign q_valid = (cnt_q != 2'd0);
	assign q_req = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= 1'b0;
			wr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= in_req;
	end
endmodule
`default_nettype wire

>>> rtl/pps_back.sv
// Back end: process table, scheduling scan and result generation.
`default_nettype none
module pps_back (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic q_valid,
	output logic q_ready,
	input wire pps_pkg::req_t q_req,
	output logic out_valid,
	input wire logic out_ready,
	output logic result_kind,
	output logic [3:0] proc_id,
	output logic idle,
	output logic switched,
	output logic finished,
	output logic [20:0] wait_time,
	output logic [20:0] turnaround,
	output logic last
);
	localparam int N = pps_pkg::MaxProcs;
	localparam int IW = pps_pkg::IdxW;
	localparam int CW = pps_pkg::CntW;

	logic [15:0] arr_q [N];
	logic [15:0] bst_q [N];
	logic [7:0] pri_q [N];
	logic [15:0] rem_q [N];
	logic [N-1:0] done_q;
	logic [20:0] wt_q [N];

	logic [20:0] now_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] prev_q;
	logic [CW-1:0] run_q;
	logic [CW-1:0] idx_q;
	logic [CW-1:0] rep_n_q;
	pps_pkg::state_t st_q, st_d;
	logic fin_q, sw_q;

	logic [N-1:0] rdy;
	logic [N-1:0] inrange;
	logic [IW-1:0] idx;
	logic [IW-1:0] rix;
	logic better;
	logic [20:0] tat_sum;

	assign idx = idx_q[IW-1:0];
	assign rix = run_q[IW-1:0];

	always_comb begin
		for (int i = 0; i < N; i++) begin
			inrange[i] = (CW'(i) < cnt_q);
			rdy[i] = inrange[i] && !done_q[i] && ({5'd0, arr_q[i]} <= now_q);
		end
	end

	always_comb begin
		better = 1'b0;
		if (run_q[IW]) better = 1'b1;
		else if (pri_q[idx] > pri_q[rix]) better = 1'b1;
		else if (pri_q[idx] == pri_q[rix] && arr_q[idx] <= arr_q[rix]) better = 1'b1;
	end

	assign tat_sum = (({1'b0, wt_q[idx]} + 22'(bst_q[idx])) > 22'(pps_pkg::Max21)) ?
		pps_pkg::Max21 : 21'(wt_q[idx] + 21'(bst_q[idx]));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= pps_pkg::ST_IDLE;
		else st_q <= st_d;
	end

	always_comb begin
		st_d = st_q;
		q_ready = 1'b0;
		out_valid = 1'b0;
		case (st_q)
			pps_pkg::ST_IDLE: begin
				q_ready = 1'b1;
				if (q_valid) begin
					case (q_req.mode)
						pps_pkg::MODE_TICK: st_d = pps_pkg::ST_SCAN;
						pps_pkg::MODE_REPORT:
							if (cnt_q != '0) st_d = pps_pkg::ST_REP;
						default: st_d = pps_pkg::ST_IDLE;
					endcase
				end
			end
			pps_pkg::ST_SCAN:
				if (idx_q == CW'(N - 1) || idx_q + 1'b1 >= cnt_q || cnt_q == '0)
					st_d = pps_pkg::ST_UPD;
			pps_pkg::ST_UPD: st_d = pps_pkg::ST_TOUT;
			pps_pkg::ST_TOUT: begin
				out_valid = 1'b1;
				if (out_ready) st_d = pps_pkg::ST_IDLE;
			end
			pps_pkg::ST_REP: begin
				out_valid = 1'b1;
				if (out_ready && idx_q + 1'b1 == rep_n_q) st_d = pps_pkg::ST_IDLE;
			end
			default: st_d = pps_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q <= '0;
			cnt_q <= '0;
			prev_q <= CW'(N);
			run_q <= CW'(N);
			idx_q <= '0;
			rep_n_q <= '0;
			fin_q <= 1'b0;
			sw_q <= 1'b0;
		end else begin
			case (st_q)
				pps_pkg::ST_IDLE:
					if (q_valid) begin
						idx_q <= '0;
						run_q <= CW'(N);
						rep_n_q <= (cnt_q > CW'(pps_pkg::MaxReport)) ?
							CW'(pps_pkg::MaxReport) : cnt_q;
						case (q_req.mode)
							pps_pkg::MODE_LOAD:
								if (cnt_q < CW'(N)) cnt_q <= cnt_q + 1'b1;
							pps_pkg::MODE_CLEAR: begin
								cnt_q <= '0;
								now_q <= '0;
								prev_q <= CW'(N);
							end
							default: ;
						endcase
					end
				pps_pkg::ST_SCAN: begin
					if (cnt_q != '0 && rdy[idx] && better) run_q <= idx_q;
					idx_q <= idx_q + 1'b1;
				end
				pps_pkg::ST_UPD: begin
					fin_q <= !run_q[IW] && rem_q[rix] == 16'd1;
					sw_q <= run_q != prev_q;
					prev_q <= run_q;
					if (now_q != pps_pkg::Max21) now_q <= now_q + 1'b1;
				end
				pps_pkg::ST_REP:
					if (out_ready) idx_q <= idx_q + 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == pps_pkg::ST_IDLE && q_valid && q_req.mode == pps_pkg::MODE_LOAD &&
				cnt_q < CW'(N)) begin
			arr_q[cnt_q[IW-1:0]] <= q_req.arrival;
			bst_q[cnt_q[IW-1:0]] <= q_req.burst;
			pri_q[cnt_q[IW-1:0]] <= q_req.prio;
			rem_q[cnt_q[IW-1:0]] <= q_req.burst;
			done_q[cnt_q[IW-1:0]] <= (q_req.burst == 16'd0);
			wt_q[cnt_q[IW-1:0]] <= '0;
		end
		if (st_q == pps_pkg::ST_UPD && !run_q[IW]) begin
			rem_q[rix] <= rem_q[rix] - 1'b1;
			if (rem_q[rix] == 16'd1) done_q[rix] <= 1'b1;
			for (int i = 0; i < N; i++) begin
				if (IW'(i) != rix && rdy[i] && wt_q[i] != pps_pkg::Max21)
					wt_q[i] <= wt_q[i] + 1'b1;
			end
		end
	end

	always_comb begin
		if (st_q == pps_pkg::ST_REP) begin
			result_kind = 1'b1;
			proc_id = 4'(idx_q);
			idle = 1'b0;
			switched = 1'b0;
			finished = 1'b0;
			wait_time = wt_q[idx];
			turnaround = tat_sum;
			last = (idx_q + 1'b1 == rep_n_q);
		end else begin
			result_kind = 1'b0;
			proc_id = run_q[IW] ? 4'd0 : 4'(rix);
			idle = run_q[IW];
			switched = sw_q;
			finished = fin_q;
			wait_time = '0;
			turnaround = '0;
			last = 1'b1;
		end
	end
endmodule
`default_nettype wire
